// ===== hdl/ssd_pkg.sv =====
`default_nettype none
package ssd_pkg;

  localparam int MAX_N_DEF = 64;
  localparam int MAX_R_DEF = 8;

  localparam int WORD_W = 64;
  localparam int POS_W = 6;
  localparam int LEN_W = 7;
  localparam int MSG_W = 6;
  localparam int SLOT_W = 8;
  localparam int WT_W = 7;
  localparam int FUNC_W = 2;
  localparam int ENTRY_W = 8;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [FUNC_W-1:0] FUNC_ROW = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WEIGHT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DECODE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LENGTH = 1'd1;

  localparam logic [LEN_W-1:0] CODE_LENGTH_RST = 7'd7;
  localparam logic [MSG_W-1:0] MESSAGE_LENGTH_RST = 6'd4;

  localparam logic signed [ENTRY_W-1:0] WEIGHT_MISSING = -8'sd1;
  localparam logic [ENTRY_W-1:0] ENTRY_EMPTY = 8'h00;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
  } row_wr_t;

  // bits below w set, w up to 64
  function automatic logic [WORD_W-1:0] low_mask(input logic [LEN_W-1:0] w);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (LEN_W'(i) < w);
    end
    return m;
  endfunction

  // missing entries weigh -1
  function automatic logic signed [ENTRY_W-1:0] entry_weight(
    input logic [ENTRY_W-1:0] e
  );
    logic signed [ENTRY_W-1:0] w;
    if (e[ENTRY_W-1]) begin
      w = signed'({1'b0, e[WT_W-1:0]});
    end else begin
      w = WEIGHT_MISSING;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ssd_syndrome.sv =====
`default_nettype none
module ssd_syndrome #(
  parameter int MAX_R = ssd_pkg::MAX_R_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  ssd_pkg::row_wr_t               row_wr,
  input  wire  [ssd_pkg::WORD_W-1:0]     row_data,
  input  wire  [ssd_pkg::WORD_W-1:0]     word,
  input  wire  [ssd_pkg::POS_W-1:0]      pos,
  input  wire  [ssd_pkg::LEN_W-1:0]      r_len,
  output logic [MAX_R-1:0]               syn_full,
  output logic [MAX_R-1:0]               col
);
  import ssd_pkg::*;

  logic [WORD_W-1:0] rows [MAX_R];

  for (genvar i = 0; i < MAX_R; i++) begin : g_row
    always_ff @(posedge clk) begin
      if (rst) begin
        rows[i] <= '0;
      end else if (row_wr.we && (32'(row_wr.slot) == i)) begin
        rows[i] <= row_data;
      end
    end

    always_comb begin
      syn_full[i] = (^(rows[i] & word)) & (32'(r_len) > i);
      col[i] = rows[i][pos] & (32'(r_len) > i);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ssd_weight_mem.sv =====
`default_nettype none
module ssd_weight_mem #(
  parameter int MAX_R = ssd_pkg::MAX_R_DEF
) (
  input  wire                          clk,
  input  wire                          we,
  input  wire  [MAX_R-1:0]             waddr,
  input  wire  [ssd_pkg::ENTRY_W-1:0]  wdata,
  input  wire  [MAX_R-1:0]             raddr_a,
  input  wire  [MAX_R-1:0]             raddr_b,
  output logic [ssd_pkg::ENTRY_W-1:0]  rdata_a,
  output logic [ssd_pkg::ENTRY_W-1:0]  rdata_b
);
  import ssd_pkg::*;

  localparam int DEPTH = 1 << MAX_R;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// ===== hdl/step_by_step_syndrome_decoder.sv =====
// step-by-step syndrome decoder for a binary linear code
// input channel (in_valid/in_stall) carries func, slot, weight, bits;
// func 0 loads a check row, func 1 a coset weight entry, func 2 decodes,
// func 3 is dropped. only decode transactions produce an output
// transaction (out_valid/out_stall, decoded).
// config writes (cfg_write, cfg_index, cfg_data) set code length n and
// message length k; write them only while the block is idle.
// loads are taken without leaving the idle state. a decode runs from
// acceptance through a state for the initial syndrome, then per bit
// position a state for the two reads of the weight memory and one to
// compare and update, then one to load the output register; a zero-weight
// syndrome ends the scan early, and n = 0 skips it.
// one transaction is worked on at a time; the next is accepted once the
// result sits in the output register, which holds it while out_stall is high.
// a decode that finishes while the output register is still stalled waits.
// after reset the weight memory is cleared one entry per cycle, all 2^MAX_R
// entries, with in_stall high; check rows clear at once and n, k return
// to 7 and 4.
`default_nettype none
module step_by_step_syndrome_decoder #(
  parameter int MAX_N = ssd_pkg::MAX_N_DEF,
  parameter int MAX_R = ssd_pkg::MAX_R_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire  [ssd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [ssd_pkg::CFG_W-1:0]      cfg_data,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [ssd_pkg::FUNC_W-1:0]     func,
  input  wire  [ssd_pkg::SLOT_W-1:0]     slot,
  input  wire  [ssd_pkg::WT_W-1:0]       weight,
  input  wire  [ssd_pkg::WORD_W-1:0]     bits,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [ssd_pkg::WORD_W-1:0]     decoded
);
  import ssd_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SYN   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [LEN_W-1:0] MAX_N_L = LEN_W'(MAX_N);
  localparam logic [LEN_W-1:0] MAX_R_L = LEN_W'(MAX_R);

  logic [2:0]         state;
  logic [MAX_R-1:0]   clr_addr;
  logic [LEN_W-1:0]   code_length;
  logic [MSG_W-1:0]   message_length;
  logic [LEN_W-1:0]   n_len;
  logic [MSG_W-1:0]   k_len;
  logic [LEN_W-1:0]   r_len;
  logic [WORD_W-1:0]  word;
  logic [POS_W-1:0]   pos;
  logic [MAX_R-1:0]   syn;
  logic [MAX_R-1:0]   syn_trial;

  logic               accept;
  logic [LEN_W-1:0]   n_next;
  logic [LEN_W-1:0]   r_next;
  logic [MAX_R+SLOT_W-1:0] slot_wide;
  logic               slot_in_table;
  row_wr_t            row_wr;
  logic [MAX_R-1:0]   syn_full;
  logic [MAX_R-1:0]   col;
  logic               mem_we;
  logic [MAX_R-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] rd_a;
  logic [ENTRY_W-1:0] rd_b;
  logic signed [ENTRY_W-1:0] w_cur;
  logic signed [ENTRY_W-1:0] w_trial;
  logic               last_pos;
  logic               out_load;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  always_comb begin
    n_next = (code_length > MAX_N_L) ? MAX_N_L : code_length;
    if ({1'b0, message_length} < n_next) begin
      r_next = n_next - {1'b0, message_length};
    end else begin
      r_next = '0;
    end
    if (r_next > MAX_R_L) begin
      r_next = MAX_R_L;
    end
  end

  assign slot_wide = {{MAX_R{1'b0}}, slot};
  assign slot_in_table = ((slot_wide >> MAX_R) == '0);

  assign row_wr.we = accept && (func == FUNC_ROW);
  assign row_wr.slot = slot;

  always_comb begin
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = ENTRY_EMPTY;
    end else begin
      mem_we = accept && (func == FUNC_WEIGHT) && slot_in_table;
      mem_waddr = slot_wide[MAX_R-1:0];
      mem_wdata = {1'b1, weight};
    end
  end

  ssd_syndrome #(
    .MAX_R(MAX_R)
  ) u_syndrome (
    .clk      (clk),
    .rst      (rst),
    .row_wr   (row_wr),
    .row_data (bits),
    .word     (word),
    .pos      (pos),
    .r_len    (r_len),
    .syn_full (syn_full),
    .col      (col)
  );

  ssd_weight_mem #(
    .MAX_R(MAX_R)
  ) u_weight_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (syn),
    .raddr_b (syn ^ col),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign w_cur = entry_weight(rd_a);
  assign w_trial = entry_weight(rd_b);
  assign last_pos = ({1'b0, pos} == (n_len - LEN_W'(1)));
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= CODE_LENGTH_RST;
      message_length <= MESSAGE_LENGTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CODE_LENGTH: code_length <= cfg_data;
        CFG_MESSAGE_LENGTH: message_length <= cfg_data[MSG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + MAX_R'(1);
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (func == FUNC_DECODE)) begin
            state <= S_SYN;
          end
        end
        S_SYN: begin
          state <= (n_len == '0) ? S_DONE : S_READ;
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if ((w_cur == '0) || last_pos) begin
            state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (func == FUNC_DECODE)) begin
      n_len <= n_next;
      k_len <= message_length;
      r_len <= r_next;
      word <= bits & low_mask(n_next);
      pos <= '0;
    end
    if (state == S_SYN) begin
      syn <= syn_full;
    end
    if (state == S_READ) begin
      syn_trial <= syn ^ col;
    end
    if ((state == S_CMP) && (w_cur != '0)) begin
      if (w_trial < w_cur) begin
        word <= word ^ (WORD_W'(1) << pos);
        syn <= syn_trial;
      end
      pos <= pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      decoded <= word & low_mask({1'b0, k_len});
    end
  end

  a_rst_clears: assert property (@(posedge clk) rst |=> (state == S_CLEAR))
    else $error("reset did not start the table clear");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ({1'b0, pos} < n_len))
    else $error("scan position beyond code length");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && (state == S_IDLE)))
    else $error("finished decode did not present a result");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !accept)
    else $error("transaction accepted during table clear");

endmodule
`default_nettype wire

// ===== tb/step_by_step_syndrome_decoder_tb.sv =====
module step_by_step_syndrome_decoder_tb;
  import ssd_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int ROWS = MAX_R_DEF;
  localparam int SYNDROMES = 1 << MAX_R_DEF;
  localparam int SCAN_CYCLES = 2 * MAX_N_DEF + 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEM_TARGET = 1200;

  class message_scoreboard;
    logic [WORD_W-1:0]  rows [ROWS];
    logic [ENTRY_W-1:0] coset_weights [SYNDROMES];
    logic [LEN_W-1:0]   code_len;
    logic [MSG_W-1:0]   msg_len;
    logic [WORD_W-1:0]  pending_messages [$];
    int                 errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      foreach (coset_weights[i]) coset_weights[i] = ENTRY_EMPTY;
      code_len = CODE_LENGTH_RST;
      msg_len = MESSAGE_LENGTH_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_CODE_LENGTH) code_len = data[LEN_W-1:0];
      else msg_len = data[MSG_W-1:0];
    endfunction

    function logic [WORD_W-1:0] span(int w);
      if (w >= WORD_W) return '1;
      return (64'd1 << w) - 64'd1;
    endfunction

    function int scan_length();
      return (code_len > MAX_N_DEF) ? MAX_N_DEF : int'(code_len);
    endfunction

    function int check_bits();
      int n;
      int r;
      n = scan_length();
      r = (int'(msg_len) < n) ? n - int'(msg_len) : 0;
      return (r > ROWS) ? ROWS : r;
    endfunction

    function int syndrome_of(logic [WORD_W-1:0] word);
      int s;
      int r;
      s = 0;
      r = check_bits();
      for (int i = 0; i < r; i++) begin
        if (^(rows[i] & word)) s = s | (1 << i);
      end
      return s;
    endfunction

    // missing entries weigh -1
    function int weight_of(int s);
      logic [ENTRY_W-1:0] e;
      e = coset_weights[s];
      if (e[ENTRY_W-1]) return int'(e[WT_W-1:0]);
      return -1;
    endfunction

    function logic [WORD_W-1:0] correct_word(logic [WORD_W-1:0] received);
      int n;
      int w;
      int tw;
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] trial;
      n = scan_length();
      word = received & span(n);
      for (int j = 0; j < n; j++) begin
        w = weight_of(syndrome_of(word));
        if (w == 0) break;
        trial = word ^ (64'd1 << j);
        tw = weight_of(syndrome_of(trial));
        if (tw < w) word = trial;
      end
      return word & span(int'(msg_len));
    endfunction

    function void note_transaction(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] s,
                                   logic [WT_W-1:0] wt, logic [WORD_W-1:0] b);
      case (f)
        FUNC_ROW: begin
          if (s < ROWS) rows[s] = b;
        end
        FUNC_WEIGHT: begin
          coset_weights[s] = {1'b1, wt};
        end
        FUNC_DECODE: begin
          pending_messages.push_back(correct_word(b));
        end
        default: begin
        end
      endcase
    endfunction

    function void check_decoded(logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (pending_messages.size() == 0) begin
        $error("decoded: expected no transaction, actual %h", got);
        errors++;
      end else begin
        want = pending_messages.pop_front();
        if (got !== want) begin
          $error("decoded: expected %h, actual %h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [FUNC_W-1:0]    func;
  logic [SLOT_W-1:0]    slot;
  logic [WT_W-1:0]      weight;
  logic [WORD_W-1:0]    bits;
  logic                 out_valid;
  logic                 out_stall;
  logic [WORD_W-1:0]    decoded;

  message_scoreboard msg_sb;
  int idle_cycles;
  int items_sent;
  int hold_off;
  bit sender_calm;
  bit receiver_calm;

  step_by_step_syndrome_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .slot      (slot),
    .weight    (weight),
    .bits      (bits),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .decoded   (decoded)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) msg_sb.check_decoded(decoded);
      if (in_valid && !in_stall) msg_sb.note_transaction(func, slot, weight, bits);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("step_by_step_syndrome_decoder_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output side: random stalls, plus long hold-offs on request
  initial begin : receiver
    int w;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall = 1'b1;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      w = receiver_calm ? 0 : $urandom_range(0, 16);
      if (w > 0) begin
        out_stall = 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SLOT_W-1:0] s,
                           input logic [WT_W-1:0] wt, input logic [WORD_W-1:0] b);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func = f;
    slot = s;
    weight = wt;
    bits = b;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    if (!(f == FUNC_NONE || (f == FUNC_ROW && s >= ROWS))) items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    msg_sb.write_reg(idx, data);
  endtask

  // wait for every decode to come out, then let any load settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (msg_sb.pending_messages.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0)
        send_item(FUNC_NONE, SLOT_W'($urandom), WT_W'($urandom), {$urandom, $urandom});
      else
        send_item(FUNC_ROW, SLOT_W'($urandom_range(ROWS, 255)), WT_W'($urandom),
                  {$urandom, $urandom});
    end
  endtask

  task automatic run_code_phase(input int phase_no);
    int n;
    int k;
    int r;
    int n_eff;
    int count;
    int flips;
    int j1;
    int j2;
    logic [WORD_W-1:0] word;
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(65, 127);
        k = $urandom_range(56, 63);
      end
      1: begin
        n = $urandom_range(0, 3);
        k = $urandom_range(0, 3);
      end
      2: begin
        n = $urandom_range(1, 20);
        k = $urandom_range(n, 63);
      end
      3: begin
        n = $urandom_range(40, 64);
        k = n - $urandom_range(1, 8);
      end
      default: begin
        n = $urandom_range(2, 16);
        r = $urandom_range(1, (n < ROWS) ? n : ROWS);
        k = n - r;
      end
    endcase
    sender_calm = ($urandom_range(0, 3) == 0);
    receiver_calm = ($urandom_range(0, 3) == 0);
    write_reg(CFG_CODE_LENGTH, CFG_W'(n));
    write_reg(CFG_MESSAGE_LENGTH, CFG_W'(k) | CFG_W'($urandom_range(0, 1) << MSG_W));
    n_eff = msg_sb.scan_length();

    for (int i = 0; i < ROWS; i++) begin
      maybe_noise();
      send_item(FUNC_ROW, SLOT_W'(i), WT_W'($urandom), {$urandom, $urandom});
    end

    // coset weights: zero syndrome, single errors, a few double errors, random extras
    send_item(FUNC_WEIGHT, SLOT_W'(0), WT_W'(0), {$urandom, $urandom});
    for (int j = 0; j < n_eff; j++) begin
      maybe_noise();
      send_item(FUNC_WEIGHT, SLOT_W'(msg_sb.syndrome_of(64'd1 << j)),
                ($urandom_range(0, 7) == 0) ? WT_W'($urandom) : WT_W'(1), '0);
    end
    if (n_eff > 1) begin
      repeat ($urandom_range(1, 4)) begin
        j1 = $urandom_range(0, n_eff - 1);
        j2 = $urandom_range(0, n_eff - 1);
        send_item(FUNC_WEIGHT, SLOT_W'(msg_sb.syndrome_of((64'd1 << j1) ^ (64'd1 << j2))),
                  WT_W'(2), '0);
      end
    end
    repeat ($urandom_range(0, 2))
      send_item(FUNC_WEIGHT, SLOT_W'($urandom), WT_W'($urandom), {$urandom, $urandom});

    if (phase_no % 8 == 1) begin
      sender_calm = 1'b1;
      hold_off = 300;
    end
    count = $urandom_range(8, 24);
    repeat (count) begin
      maybe_noise();
      case ($urandom_range(0, 3))
        0: word = {$urandom, $urandom};
        1: word = ($urandom_range(0, 1) == 0) ? '0 : '1;
        default: begin
          word = '0;
          if (n_eff > 0) begin
            flips = $urandom_range(0, 3);
            repeat (flips) word = word ^ (64'd1 << $urandom_range(0, n_eff - 1));
          end
          if ($urandom_range(0, 1) == 0)
            word = word | ({$urandom, $urandom} & ~msg_sb.span(n_eff));
        end
      endcase
      send_item(FUNC_DECODE, SLOT_W'($urandom), WT_W'($urandom), word);
    end
    drain();
  endtask

  initial begin : stimulus
    int phase_no;
    msg_sb = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = '0;
    slot = '0;
    weight = '0;
    bits = '0;
    items_sent = 0;
    hold_off = 0;
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    do @(posedge clk); while (in_stall);

    // empty weight memory, unused func, ignored row slots, then a small code and two decodes
    send_item(FUNC_DECODE, '0, '0, '1);
    send_item(FUNC_NONE, '1, '1, '1);
    send_item(FUNC_ROW, SLOT_W'(0), '0, 64'h55);
    send_item(FUNC_ROW, SLOT_W'(1), '0, 64'h66);
    send_item(FUNC_ROW, SLOT_W'(2), '0, 64'h78);
    send_item(FUNC_ROW, '1, '1, '1);
    send_item(FUNC_ROW, SLOT_W'(ROWS), '0, '1);
    send_item(FUNC_WEIGHT, '0, '0, '0);
    for (int s = 1; s < 8; s++) send_item(FUNC_WEIGHT, SLOT_W'(s), WT_W'(1), '0);
    send_item(FUNC_WEIGHT, '1, '1, '1);
    send_item(FUNC_DECODE, '0, '0, 64'hFFFF_FFFF_FFFF_FF04);
    send_item(FUNC_DECODE, '0, '0, '0);
    drain();

    // length above the maximum, message length bit beyond its width
    write_reg(CFG_CODE_LENGTH, '1);
    write_reg(CFG_MESSAGE_LENGTH, '1);
    send_item(FUNC_DECODE, '0, '0, '1);
    drain();

    // zero length
    write_reg(CFG_CODE_LENGTH, '0);
    write_reg(CFG_MESSAGE_LENGTH, '0);
    send_item(FUNC_DECODE, '0, '0, '1);
    drain();

    // full length, widest syndrome
    write_reg(CFG_CODE_LENGTH, CFG_W'(MAX_N_DEF));
    send_item(FUNC_DECODE, '0, '0, {$urandom, $urandom});
    send_item(FUNC_DECODE, '0, '0, '1);
    drain();

    // message not shorter than word
    write_reg(CFG_CODE_LENGTH, CFG_W'(5));
    write_reg(CFG_MESSAGE_LENGTH, CFG_W'(40));
    send_item(FUNC_DECODE, '0, '0, '1);
    drain();

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      run_code_phase(phase_no);
      phase_no++;
    end

    if (msg_sb.errors == 0 && msg_sb.pending_messages.size() == 0) begin
      $display("step_by_step_syndrome_decoder_tb OK");
    end else begin
      $display("step_by_step_syndrome_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule
